// ===== src/sliding_window_maximum_core_assert.svh =====
// ----------------------------------------------------------------------------
// sliding window maximum assertion macros
// shared checker shorthands for the core's concurrent assertions
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MAXIMUM_CORE_ASSERT_SVH
`define SLIDING_WINDOW_MAXIMUM_CORE_ASSERT_SVH

// same-cycle implication
`define SWM_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("swm check failed");

// next-cycle implication
`define SWM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("swm check failed");

`endif

// ===== src/swm_pkg.sv =====
// ----------------------------------------------------------------------------
// swm_pkg
// types and constants of the sliding window maximum core
// ----------------------------------------------------------------------------
`default_nettype none

package swm_pkg;

	localparam int WINDOW_MAX  = 64;
	localparam int SAMPLE_BITS = 32;
	localparam int LEN_W       = 7;
	localparam int IDX_W       = $clog2(WINDOW_MAX);

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic [LEN_W-1:0]              len_t;
	typedef logic [IDX_W-1:0]              idx_t;

	localparam len_t LEN_ONE  = len_t'(1);
	localparam len_t LEN_FULL = len_t'(WINDOW_MAX);

endpackage

`default_nettype wire

// ===== src/swm_in_if.sv =====
// ----------------------------------------------------------------------------
// swm_in_if
// sample stream channel: valid/ready with sample and start flag
// ----------------------------------------------------------------------------
`default_nettype none

interface swm_in_if;
	import swm_pkg::*;

	logic    valid;
	logic    ready;
	sample_t sample;
	logic    start_req;

	modport source (output valid, output sample, output start_req, input ready);
	modport sink   (input valid, input sample, input start_req, output ready);
endinterface

`default_nettype wire

// ===== src/swm_out_if.sv =====
// ----------------------------------------------------------------------------
// swm_out_if
// result stream channel: valid/ready with window maximum
// ----------------------------------------------------------------------------
`default_nettype none

interface swm_out_if;
	import swm_pkg::*;

	logic    valid;
	logic    ready;
	sample_t window_max;

	modport source (output valid, output window_max, input ready);
	modport sink   (input valid, input window_max, output ready);
endinterface

`default_nettype wire

// ===== src/sliding_window_maximum_core.sv =====
// ----------------------------------------------------------------------------
// sliding_window_maximum_core
// streaming maximum over the last window_len signed samples
// ----------------------------------------------------------------------------
// Takes one sample per cycle unless stalled. A chain of WINDOW_MAX cells
// holds, in cell k, the maximum of the newest k+1 samples; on each transaction
// every cell compares the new sample with its neighbor's value, so the
// throughput is set by one 32-bit compare per cell plus the tap select that
// picks cell window_len-2. The result is registered and appears the cycle
// after the sample is accepted; while it waits to be taken the next sample is
// still accepted as long as the output register is freed in the same cycle.
// No result is given until the current sequence holds window_len samples.
// window_len of 0 acts as 1, above 64 acts as 64; write it only while idle.
`default_nettype none

module sliding_window_maximum_core (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                cfg_wr_en,
	input  wire swm_pkg::len_t cfg_wr_data,
	swm_in_if.sink             in_ch,
	swm_out_if.source          out_ch
);
	import swm_pkg::*;

	len_t    window_len_q;
	len_t    fill_q;
	len_t    fill_d;
	len_t    len_eff;
	len_t    tap_sel;
	idx_t    tap_idx;
	logic    accept;
	logic    emit;
	logic    out_valid_q;
	sample_t out_data_q;
	sample_t result;
	sample_t tap;
	sample_t m [WINDOW_MAX];

	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign accept      = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q <= LEN_ONE;
		end else if (cfg_wr_en) begin
			window_len_q <= cfg_wr_data;
		end
	end

	// cell chain, cell 0 sees the new sample as its neighbor
	for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
		if (g == 0) begin : g_head
			swm_cell u_cell (
				.clk   (clk),
				.en    (accept),
				.start (in_ch.start_req),
				.x     (in_ch.sample),
				.prev  (in_ch.sample),
				.m     (m[g])
			);
		end else begin : g_body
			swm_cell u_cell (
				.clk   (clk),
				.en    (accept),
				.start (in_ch.start_req),
				.x     (in_ch.sample),
				.prev  (m[g-1]),
				.m     (m[g])
			);
		end
	end

	always_comb begin
		if (window_len_q == '0) begin
			len_eff = LEN_ONE;
		end else if (window_len_q > LEN_FULL) begin
			len_eff = LEN_FULL;
		end else begin
			len_eff = window_len_q;
		end
	end

	always_comb begin
		if (in_ch.start_req) begin
			fill_d = LEN_ONE;
		end else if (fill_q < LEN_FULL) begin
			fill_d = fill_q + LEN_ONE;
		end else begin
			fill_d = fill_q;
		end
	end

	assign emit = (fill_d >= len_eff);

	// window of len ends at the cell holding the newest len-1 old samples
	assign tap_sel = len_eff - len_t'(2);
	assign tap_idx = tap_sel[IDX_W-1:0];
	assign tap     = m[tap_idx];

	always_comb begin
		if ((len_eff == LEN_ONE) || (in_ch.sample > tap)) begin
			result = in_ch.sample;
		end else begin
			result = tap;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				fill_q <= fill_d;
			end
			if (accept) begin
				out_valid_q <= emit;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			out_data_q <= result;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.window_max = out_data_q;

`include "sliding_window_maximum_core_assert.svh"

	`SWM_ASSERT_NOW(a_fill_bound, 1'b1, fill_q <= LEN_FULL)
	`SWM_ASSERT_NEXT(a_start_fill, accept && in_ch.start_req, fill_q == LEN_ONE)
	`SWM_ASSERT_NOW(a_result_src, $rose(out_valid_q), $past(accept))
	`SWM_ASSERT_NEXT(a_fill_sat, accept && !in_ch.start_req && (fill_q == LEN_FULL),
		fill_q == LEN_FULL)
endmodule

`default_nettype wire

// ===== src/swm_cell.sv =====
// ----------------------------------------------------------------------------
// swm_cell
// one stage of the running-maximum chain: max of the newest k+1 samples
// ----------------------------------------------------------------------------
`default_nettype none

module swm_cell (
	input  wire            clk,
	input  wire            en,
	input  wire            start,
	input  wire swm_pkg::sample_t x,
	input  wire swm_pkg::sample_t prev,
	output swm_pkg::sample_t m
);
	import swm_pkg::*;

	sample_t m_q;
	sample_t m_d;

	// a new sequence forgets the neighbor's history
	always_comb begin
		if (start || (x > prev)) begin
			m_d = x;
		end else begin
			m_d = prev;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_q <= m_d;
		end
	end

	assign m = m_q;
endmodule

`default_nettype wire
